FILE: sv/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold on every clock outside reset
`define WAVHP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define WAVHP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/wavhp_pkg.sv
// types, codes and constants of the wav header parser
`timescale 1ns / 1ps
package wavhp_pkg;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;
  localparam logic [31:0] FMT_MIN_SIZE = 32'd16;
  localparam logic [15:0] MAX_CHANNELS = 16'd2;
  localparam logic [15:0] FMT_PCM = 16'd1;
  localparam logic [15:0] BITS_16 = 16'd16;
  localparam logic [31:0] MAX_DATA_SIZE_RST = 32'd4194304;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_DATA_SIZE = 3'd0;

  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_BAD_RIFF  = 4'd1,
    ST_BAD_WAVE  = 4'd2,
    ST_SHORT_FMT = 4'd3,
    ST_TRUNCATED = 4'd4,
    ST_NOT_PCM   = 4'd5,
    ST_NOT_16BIT = 4'd6,
    ST_BAD_CHANS = 4'd7,
    ST_TOO_LARGE = 4'd8
  } status_t;

  typedef enum logic [12:0] {
    PH_RIFF  = 13'b0_0000_0000_0001,
    PH_RSIZE = 13'b0_0000_0000_0010,
    PH_WAVE  = 13'b0_0000_0000_0100,
    PH_CID   = 13'b0_0000_0000_1000,
    PH_FSIZE = 13'b0_0000_0001_0000,
    PH_F0    = 13'b0_0000_0010_0000,
    PH_F1    = 13'b0_0000_0100_0000,
    PH_F2    = 13'b0_0000_1000_0000,
    PH_F3    = 13'b0_0001_0000_0000,
    PH_SKIP  = 13'b0_0010_0000_0000,
    PH_DONE  = 13'b0_0100_0000_0000,
    PH_DSIZE = 13'b0_1000_0000_0000,
    PH_OSIZE = 13'b1_0000_0000_0000
  } phase_t;

  // first member is the most significant, so status lands in the low bits
  typedef struct packed {
    logic [31:0] payload_offset;
    logic [31:0] payload_len;
    logic [15:0] sample_bits;
    logic [15:0] frame_bytes;
    logic [31:0] rate_hz;
    logic [15:0] channel_count;
    logic [15:0] format_code;
    status_t     status;
  } result_t;

  typedef struct packed {
    logic at_start;
    logic sent;
  } parse_stat_t;

endpackage

FILE: sv/wavhp_parse.sv
// byte-wise riff/wave parser state and field capture
`timescale 1ns / 1ps
module wavhp_parse
  import wavhp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        byte_take,
  input  logic [7:0]  byte_value,
  input  logic        stream_end,
  input  logic [31:0] max_data_size,
  output logic        res_valid,
  output result_t     res,
  output parse_stat_t pstat
);

  phase_t      phase_r, phase_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [31:0] shift_r, shift_nxt;
  logic [31:0] remain_r, remain_nxt;
  logic        fmt_seen_r, fmt_seen_nxt;
  logic        sent_r, sent_nxt;
  logic [31:0] pos_r, pos_nxt;
  logic [15:0] format_r, format_nxt;
  logic [15:0] chans_r, chans_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic [15:0] align_r, align_nxt;
  logic [15:0] bits_r, bits_nxt;
  logic [31:0] dsize_r, dsize_nxt;
  logic [31:0] doff_r, doff_nxt;

  logic        take;
  logic        full;
  logic [31:0] v;
  logic        emit;
  status_t     code;
  status_t     fin_code;

  assign take = (phase_r != PH_DONE) && (phase_r != PH_SKIP);
  assign v    = {byte_value, shift_r[31:8]};
  assign full = take && (cnt_r == 2'd3);

  always_comb begin
    if (format_r != FMT_PCM) begin
      fin_code = ST_NOT_PCM;
    end else if (bits_r != BITS_16) begin
      fin_code = ST_NOT_16BIT;
    end else if (chans_r == 16'd0 || chans_r > MAX_CHANNELS) begin
      fin_code = ST_BAD_CHANS;
    end else if (v > max_data_size) begin
      fin_code = ST_TOO_LARGE;
    end else begin
      fin_code = ST_OK;
    end
  end

  always_comb begin
    phase_nxt    = phase_r;
    cnt_nxt      = cnt_r;
    shift_nxt    = shift_r;
    remain_nxt   = remain_r;
    fmt_seen_nxt = fmt_seen_r;
    sent_nxt     = sent_r;
    pos_nxt      = pos_r + 32'd1;
    format_nxt   = format_r;
    chans_nxt    = chans_r;
    rate_nxt     = rate_r;
    align_nxt    = align_r;
    bits_nxt     = bits_r;
    dsize_nxt    = dsize_r;
    doff_nxt     = doff_r;
    emit         = 1'b0;
    code         = ST_OK;

    if (take) begin
      shift_nxt = v;
      cnt_nxt   = cnt_r + 2'd1;
    end

    case (phase_r)
      PH_RIFF: begin
        if (full) begin
          if (v == TAG_RIFF) begin
            phase_nxt = PH_RSIZE;
          end else begin
            emit = 1'b1;
            code = ST_BAD_RIFF;
          end
        end
      end
      PH_RSIZE: begin
        if (full) phase_nxt = PH_WAVE;
      end
      PH_WAVE: begin
        if (full) begin
          if (v == TAG_WAVE) begin
            phase_nxt = PH_CID;
          end else begin
            emit = 1'b1;
            code = ST_BAD_WAVE;
          end
        end
      end
      PH_CID: begin
        if (full) begin
          if (v == TAG_FMT) begin
            phase_nxt = PH_FSIZE;
          end else if (v == TAG_DATA) begin
            phase_nxt = PH_DSIZE;
          end else begin
            phase_nxt = PH_OSIZE;
          end
        end
      end
      PH_FSIZE: begin
        if (full) begin
          if (v < FMT_MIN_SIZE) begin
            emit = 1'b1;
            code = ST_SHORT_FMT;
          end else begin
            remain_nxt = v - FMT_MIN_SIZE;
            phase_nxt  = PH_F0;
          end
        end
      end
      PH_F0: begin
        if (full) begin
          format_nxt = v[15:0];
          chans_nxt  = v[31:16];
          phase_nxt  = PH_F1;
        end
      end
      PH_F1: begin
        if (full) begin
          rate_nxt  = v;
          phase_nxt = PH_F2;
        end
      end
      PH_F2: begin
        if (full) phase_nxt = PH_F3;
      end
      PH_F3: begin
        if (full) begin
          align_nxt    = v[15:0];
          bits_nxt     = v[31:16];
          fmt_seen_nxt = 1'b1;
          phase_nxt    = (remain_r == 32'd0) ? PH_CID : PH_SKIP;
        end
      end
      PH_DSIZE: begin
        if (full) begin
          if (fmt_seen_r) begin
            dsize_nxt = v;
            doff_nxt  = pos_nxt;
            emit      = 1'b1;
            code      = fin_code;
          end else begin
            remain_nxt = v;
            phase_nxt  = (v == 32'd0) ? PH_CID : PH_SKIP;
          end
        end
      end
      PH_OSIZE: begin
        if (full) begin
          remain_nxt = v;
          phase_nxt  = (v == 32'd0) ? PH_CID : PH_SKIP;
        end
      end
      PH_SKIP: begin
        remain_nxt = remain_r - 32'd1;
        if (remain_r == 32'd1) phase_nxt = PH_CID;
      end
      default: begin
      end
    endcase

    if (emit) begin
      sent_nxt  = 1'b1;
      phase_nxt = PH_DONE;
    end

    if (stream_end && !sent_nxt) begin
      emit = 1'b1;
      code = ST_TRUNCATED;
    end

    res.status         = code;
    res.format_code    = format_nxt;
    res.channel_count  = chans_nxt;
    res.rate_hz        = rate_nxt;
    res.frame_bytes    = align_nxt;
    res.sample_bits    = bits_nxt;
    res.payload_len    = dsize_nxt;
    res.payload_offset = doff_nxt;
    res_valid          = byte_take && emit;

    // restart after the last byte of a file
    if (stream_end) begin
      phase_nxt    = PH_RIFF;
      cnt_nxt      = 2'd0;
      shift_nxt    = 32'd0;
      remain_nxt   = 32'd0;
      fmt_seen_nxt = 1'b0;
      sent_nxt     = 1'b0;
      pos_nxt      = 32'd0;
      format_nxt   = 16'd0;
      chans_nxt    = 16'd0;
      rate_nxt     = 32'd0;
      align_nxt    = 16'd0;
      bits_nxt     = 16'd0;
      dsize_nxt    = 32'd0;
      doff_nxt     = 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_RIFF;
      cnt_r      <= 2'd0;
      shift_r    <= 32'd0;
      remain_r   <= 32'd0;
      fmt_seen_r <= 1'b0;
      sent_r     <= 1'b0;
      pos_r      <= 32'd0;
      format_r   <= 16'd0;
      chans_r    <= 16'd0;
      rate_r     <= 32'd0;
      align_r    <= 16'd0;
      bits_r     <= 16'd0;
      dsize_r    <= 32'd0;
      doff_r     <= 32'd0;
    end else if (byte_take) begin
      phase_r    <= phase_nxt;
      cnt_r      <= cnt_nxt;
      shift_r    <= shift_nxt;
      remain_r   <= remain_nxt;
      fmt_seen_r <= fmt_seen_nxt;
      sent_r     <= sent_nxt;
      pos_r      <= pos_nxt;
      format_r   <= format_nxt;
      chans_r    <= chans_nxt;
      rate_r     <= rate_nxt;
      align_r    <= align_nxt;
      bits_r     <= bits_nxt;
      dsize_r    <= dsize_nxt;
      doff_r     <= doff_nxt;
    end
  end

  assign pstat.at_start = (phase_r == PH_RIFF) && (pos_r == 32'd0) && (cnt_r == 2'd0);
  assign pstat.sent     = sent_r;

endmodule

FILE: sv/wavhp_outq.sv
// two-entry result queue between the parser and the output channel
`timescale 1ns / 1ps
module wavhp_outq
  import wavhp_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  output logic    pop_valid,
  input  logic    pop_ready,
  output result_t pop_data
);

  result_t    mem [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;

  assign pop       = pop_valid && pop_ready;
  assign pop_valid = (cnt_r != 2'd0);
  assign full      = (cnt_r == 2'd2);
  assign pop_data  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

FILE: sv/wav_header_parser.sv
// WAV header parser: takes one file byte per transaction on the input stream and returns
// one result per file with status and the fmt and data chunk fields. Every byte is handled
// in the cycle it is accepted, so a byte can be taken on every clock that in_tready is high;
// the result is written into the output queue on the deciding byte (a bad tag, a short fmt
// chunk, the data chunk header, or the last byte of a truncated file). Results wait in a
// two-entry queue, and in_tready drops only while both entries are held. max_data_size
// sits at byte address 0 of the configuration port and resets to 4194304.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module wav_header_parser
  import wavhp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,     // byte_value
  input  logic                  in_tlast,     // stream_end
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // status[3:0], format code, channel_count, rate, frame bytes,
  // sample bits, payload length, payload offset, zero fill
  output logic [167:0]          out_tdata,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  logic [31:0] max_size_r;
  logic        cfg_sel_reg;
  logic        in_accept;
  logic        q_full;
  logic        res_valid;
  result_t     res;
  result_t     q_data;
  parse_stat_t pstat;

  assign cfg_pready  = 1'b1;
  assign cfg_sel_reg = (cfg_paddr[CFG_ADDR_W-1:2] == REG_MAX_DATA_SIZE[CFG_ADDR_W-1:2]);
  assign cfg_prdata  = cfg_sel_reg ? max_size_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_size_r <= MAX_DATA_SIZE_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_sel_reg) begin
      max_size_r <= cfg_pwdata;
    end
  end

  assign in_tready = !q_full;
  assign in_accept = in_tvalid && in_tready;

  wavhp_parse u_parse (
    .clk           (clk),
    .rst_n         (rst_n),
    .byte_take     (in_accept),
    .byte_value    (in_tdata),
    .stream_end    (in_tlast),
    .max_data_size (max_size_r),
    .res_valid     (res_valid),
    .res           (res),
    .pstat         (pstat)
  );

  wavhp_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .full      (q_full),
    .pop_valid (out_tvalid),
    .pop_ready (out_tready),
    .pop_data  (q_data)
  );

  assign out_tdata = {4'd0, q_data};

  `WAVHP_ASSERT(a_no_overflow, !(res_valid && q_full), "result pushed into a full queue")
  `WAVHP_ASSERT_NEXT(a_restart, in_accept && in_tlast, pstat.at_start,
                     "parser did not restart after the last byte")
  `WAVHP_ASSERT_NEXT(a_one_result, res_valid && !in_tlast, pstat.sent,
                     "result issued but not marked as sent")
  `WAVHP_ASSERT(a_single, !(res_valid && pstat.sent), "second result for one file")

endmodule
